// ===== sv/nsc_pkg.sv =====
`timescale 1ns / 1ps

package nsc_pkg;

    localparam int BUFFER_DEPTH    = 128;
    localparam int SEPARATOR_SLOTS = 32;

    // counters must hold the full depth as well as every index below it
    localparam int WCOUNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SCOUNT_W = $clog2(SEPARATOR_SLOTS + 1);

    localparam int TAG_W    = 24;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 7;
    localparam int SLOT_W   = 5;
    localparam int RESULT_W = 33;
    localparam int TDATA_W  = 40;

    localparam logic [TAG_W-1:0]  TAG_RESET = 24'h474741;

    localparam logic [BYTE_W-1:0] CH_START = 8'h24;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // first member lands in the top bits: store_valid ends up at bit 0
    typedef struct packed {
        logic                sentence_start;
        logic                overflow;
        logic                sentence_complete;
        logic                capturing;
        logic [INDEX_W-1:0]  comma_position;
        logic [SLOT_W-1:0]   comma_slot;
        logic                comma_valid;
        logic [BYTE_W-1:0]   store_byte;
        logic [INDEX_W-1:0]  store_index;
        logic                store_valid;
    } result_t;

endpackage

// ===== sv/nsc_core.sv =====
`timescale 1ns / 1ps

module nsc_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [nsc_pkg::TAG_W-1:0]     cfg_wdata,
    input  logic                          in_accept,
    input  logic [nsc_pkg::BYTE_W-1:0]    in_byte,
    output nsc_pkg::result_t              result
);

    logic [nsc_pkg::TAG_W-1:0]    sentence_tag_reg;
    logic [nsc_pkg::TAG_W-1:0]    tag_shift_reg, tag_shift_next;
    logic                         in_capture_reg, in_capture_next;
    logic [nsc_pkg::WCOUNT_W-1:0] write_count_reg, write_count_next;
    logic [nsc_pkg::SCOUNT_W-1:0] sep_count_reg, sep_count_next;
    logic [nsc_pkg::BYTE_W-1:0]   prev_char_reg, prev_char_next;
    logic                         complete_reg, complete_next;
    logic                         overflow_reg, overflow_next;
    logic                         room;
    logic                         sep_room;

    assign room     = write_count_reg < nsc_pkg::WCOUNT_W'(nsc_pkg::BUFFER_DEPTH);
    assign sep_room = sep_count_reg < nsc_pkg::SCOUNT_W'(nsc_pkg::SEPARATOR_SLOTS);

    always_comb begin
        tag_shift_next   = tag_shift_reg;
        in_capture_next  = in_capture_reg;
        write_count_next = write_count_reg;
        sep_count_next   = sep_count_reg;
        prev_char_next   = prev_char_reg;
        complete_next    = complete_reg;
        overflow_next    = overflow_reg;
        result           = '0;

        priority if (in_byte == nsc_pkg::CH_START) begin
            // restart the sentence, keep the tag history
            result.sentence_start = 1'b1;
            in_capture_next  = 1'b0;
            write_count_next = '0;
            sep_count_next   = '0;
            prev_char_next   = '0;
            complete_next    = 1'b0;
            overflow_next    = 1'b0;
        end else if (in_capture_reg) begin
            if (in_byte == nsc_pkg::CH_COMMA) begin
                if (room && sep_room) begin
                    result.comma_valid    = 1'b1;
                    result.comma_slot     = sep_count_reg[nsc_pkg::SLOT_W-1:0];
                    result.comma_position = write_count_reg[nsc_pkg::INDEX_W-1:0];
                    sep_count_next        = sep_count_reg + 1'b1;
                end else begin
                    overflow_next = 1'b1;
                end
            end
            if (room) begin
                result.store_valid = 1'b1;
                result.store_index = write_count_reg[nsc_pkg::INDEX_W-1:0];
                result.store_byte  = in_byte;
                write_count_next   = write_count_reg + 1'b1;
            end else begin
                overflow_next = 1'b1;
            end
            if (in_byte == nsc_pkg::CH_LF) begin
                if (prev_char_reg == nsc_pkg::CH_CR) begin
                    complete_next = 1'b1;
                end
            end else begin
                prev_char_next = in_byte;
            end
        end else if (tag_shift_reg == sentence_tag_reg) begin
            // swallow the byte after the tag
            in_capture_next = 1'b1;
            tag_shift_next  = '0;
        end else begin
            tag_shift_next = {tag_shift_reg[nsc_pkg::TAG_W-nsc_pkg::BYTE_W-1:0], in_byte};
        end

        result.capturing         = in_capture_next;
        result.sentence_complete = complete_next;
        result.overflow          = overflow_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sentence_tag_reg <= nsc_pkg::TAG_RESET;
            tag_shift_reg    <= '0;
            in_capture_reg   <= 1'b0;
            write_count_reg  <= '0;
            sep_count_reg    <= '0;
            prev_char_reg    <= '0;
            complete_reg     <= 1'b0;
            overflow_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                sentence_tag_reg <= cfg_wdata;
            end
            if (in_accept) begin
                tag_shift_reg   <= tag_shift_next;
                in_capture_reg  <= in_capture_next;
                write_count_reg <= write_count_next;
                sep_count_reg   <= sep_count_next;
                prev_char_reg   <= prev_char_next;
                complete_reg    <= complete_next;
                overflow_reg    <= overflow_next;
            end
        end
    end

endmodule

// ===== sv/nsc_out_buf.sv =====
`timescale 1ns / 1ps

module nsc_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  nsc_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nsc_pkg::result_t  out_data
);

    logic             main_valid_reg;
    nsc_pkg::result_t main_data_reg;
    logic             skid_valid_reg;
    nsc_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            // drain the skid stage first; no request is taken while it is full
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== sv/nmea_sentence_capture.sv =====
`timescale 1ns / 1ps

// Captures NMEA sentences whose three-character tag matches cfg_wdata (GGA after
// reset) from a stream of received bytes, one byte per request. Every byte gives
// one result: a buffer write with its index, a separator record with its slot,
// and the capture, completion, overflow and start flags after that byte. One
// byte is taken every cycle while the skid register is empty; each result is
// registered in the output stage, through the skid register when it stalls.
// A two-deep output stage takes one more byte while a result waits downstream.
// The input then stalls until the waiting result leaves, including the cycle
// in which the second result moves up to the output.
module nmea_sentence_capture (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [nsc_pkg::TAG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] store_valid, [7:1] store_index, [15:8] store_byte, [16] comma_valid,
    // [21:17] comma_slot, [28:22] comma_position, [29] capturing,
    // [30] sentence_complete, [31] overflow, [32] sentence_start, [39:33] zero
    output logic [nsc_pkg::TDATA_W-1:0]   m_tdata
);

    nsc_pkg::result_t core_result;
    nsc_pkg::result_t out_result;
    logic             in_accept;

    assign in_accept = s_tvalid && s_tready;

    nsc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .result    (core_result)
    );

    nsc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {(nsc_pkg::TDATA_W - nsc_pkg::RESULT_W)'(0), out_result};

`ifndef SYNTHESIS
    // a separator is only recorded when the byte itself is stored
    a_comma_needs_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.comma_valid |-> out_result.store_valid)
        else $error("separator recorded without a buffer write");

    // a start character never stores and always leaves capture
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.sentence_start |->
            !out_result.store_valid && !out_result.capturing)
        else $error("start character stored or left capture on");

    a_store_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.store_valid |-> out_result.capturing)
        else $error("buffer write outside a capture");

    // input back-pressure only while a result is held
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with the output empty");
`endif

endmodule

// ===== tb/nmea_sentence_capture_tb.sv =====
`timescale 1ns / 1ps

module nmea_sentence_capture_tb;

    localparam int CLK_PERIOD  = 12;
    localparam int IDLE_PCT    = 17;
    localparam int HOLD_CYCLES = 90;
    localparam int STALL_LIMIT = 4000;

    localparam logic [nsc_pkg::TAG_W-1:0]  TAG_ZERO = '0;
    localparam logic [nsc_pkg::TAG_W-1:0]  TAG_ONES = '1;
    localparam logic [nsc_pkg::TAG_W-1:0]  TAG_RMC  = 24'h524D43;

    localparam logic [nsc_pkg::BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [nsc_pkg::BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [nsc_pkg::BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [nsc_pkg::BYTE_W-1:0] CH_DIGIT0 = 8'h30;
    localparam logic [nsc_pkg::BYTE_W-1:0] CH_UPPERA = 8'h41;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [nsc_pkg::TAG_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [nsc_pkg::BYTE_W-1:0]    s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [nsc_pkg::TDATA_W-1:0]   m_tdata;

    // bytes waiting to be offered, and results owed by the block in order
    logic [nsc_pkg::BYTE_W-1:0]    rx_pending[$];
    nsc_pkg::result_t              owed_results[$];

    // sentence tracker state
    logic [nsc_pkg::TAG_W-1:0]     tag_setting  = nsc_pkg::TAG_RESET;
    logic [nsc_pkg::TAG_W-1:0]     tag_window   = '0;
    bit                            capture_on   = 1'b0;
    int                            fill_count   = 0;
    int                            comma_count  = 0;
    logic [nsc_pkg::BYTE_W-1:0]    last_char    = '0;
    bit                            line_done    = 1'b0;
    bit                            dropped      = 1'b0;

    bit                   calm         = 1'b0;
    int                   errors       = 0;
    int                   items_queued = 0;
    int                   bytes_sent   = 0;
    int                   results_seen = 0;
    int                   hold_left    = 0;
    int                   quiet_cycles = 0;
    int                   stores_seen  = 0;
    int                   commas_seen  = 0;
    int                   overflow_seen = 0;
    int                   complete_seen = 0;

    nmea_sentence_capture u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic nsc_pkg::result_t capture_step(logic [nsc_pkg::BYTE_W-1:0] c);
        nsc_pkg::result_t r;
        bit               room;
        r = '0;
        if (c == nsc_pkg::CH_START) begin
            // restart the sentence but keep the tag window
            r.sentence_start = 1'b1;
            capture_on  = 1'b0;
            fill_count  = 0;
            comma_count = 0;
            last_char   = '0;
            line_done   = 1'b0;
            dropped     = 1'b0;
        end else if (capture_on) begin
            room = fill_count < nsc_pkg::BUFFER_DEPTH;
            if (c == nsc_pkg::CH_COMMA) begin
                if (room && comma_count < nsc_pkg::SEPARATOR_SLOTS) begin
                    r.comma_valid    = 1'b1;
                    r.comma_slot     = comma_count[nsc_pkg::SLOT_W-1:0];
                    r.comma_position = fill_count[nsc_pkg::INDEX_W-1:0];
                    comma_count++;
                end else begin
                    dropped = 1'b1;
                end
            end
            if (room) begin
                r.store_valid = 1'b1;
                r.store_index = fill_count[nsc_pkg::INDEX_W-1:0];
                r.store_byte  = c;
                fill_count++;
            end else begin
                dropped = 1'b1;
            end
            if (c == nsc_pkg::CH_LF) begin
                if (last_char == nsc_pkg::CH_CR)
                    line_done = 1'b1;
            end else begin
                last_char = c;
            end
        end else if (tag_window == tag_setting) begin
            // swallow the byte after the tag
            capture_on = 1'b1;
            tag_window = '0;
        end else begin
            tag_window = {tag_window[nsc_pkg::TAG_W-nsc_pkg::BYTE_W-1:0], c};
        end
        r.capturing         = capture_on;
        r.sentence_complete = line_done;
        r.overflow          = dropped;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                owed_results.push_back(capture_step(s_tdata));
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (rx_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_pending.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        nsc_pkg::result_t want;
        nsc_pkg::result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = nsc_pkg::result_t'(m_tdata[nsc_pkg::RESULT_W-1:0]);
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected request, expected none got %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch, expected %h got %h",
                                 $time, want, got);
                        errors++;
                    end
                    if (m_tdata[nsc_pkg::TDATA_W-1:nsc_pkg::RESULT_W] !== '0) begin
                        $display("%0t: tdata padding mismatch, expected 0 got %h", $time,
                                 m_tdata[nsc_pkg::TDATA_W-1:nsc_pkg::RESULT_W]);
                        errors++;
                    end
                    stores_seen   += int'(want.store_valid);
                    commas_seen   += int'(want.comma_valid);
                    overflow_seen += int'(want.overflow);
                    complete_seen += int'(want.sentence_complete);
                end
                results_seen++;
                // hold off for a long stretch so the block backs up into its input
                if (results_seen == 300 || results_seen == 1200)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [nsc_pkg::BYTE_W-1:0] field_char();
        int                         pick;
        logic [nsc_pkg::BYTE_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            b = CH_DIGIT0 + nsc_pkg::BYTE_W'($urandom_range(0, 9));
        else if (pick < 50)
            b = nsc_pkg::CH_COMMA;
        else if (pick < 58)
            b = CH_DOT;
        else if (pick < 66)
            b = CH_UPPERA + nsc_pkg::BYTE_W'($urandom_range(0, 25));
        else if (pick < 69)
            b = nsc_pkg::CH_CR;
        else if (pick < 72)
            b = nsc_pkg::CH_LF;
        else begin
            b = nsc_pkg::BYTE_W'($urandom_range(0, 255));
            // keep stray start characters rare inside a body
            if (b == nsc_pkg::CH_START && $urandom_range(0, 3) != 0)
                b = CH_HASH;
        end
        return b;
    endfunction

    task automatic push_byte(logic [nsc_pkg::BYTE_W-1:0] b);
        rx_pending.push_back(b);
        items_queued++;
    endtask

    task automatic push_tag(logic [nsc_pkg::TAG_W-1:0] t);
        push_byte(t[23:16]);
        push_byte(t[15:8]);
        push_byte(t[7:0]);
    endtask

    task automatic push_sentence(logic [nsc_pkg::TAG_W-1:0] t);
        int                        shape;
        int                        pick;
        int                        body_len;
        logic [nsc_pkg::TAG_W-1:0] sent_tag;
        shape    = $urandom_range(0, 99);
        sent_tag = t;
        pick     = $urandom_range(0, 99);
        if (pick < 8)
            sent_tag = nsc_pkg::TAG_W'($urandom());
        else if (pick < 15)
            sent_tag[8 * $urandom_range(0, 2) +: 8] = nsc_pkg::BYTE_W'($urandom());
        if ($urandom_range(0, 9) != 0)
            push_byte(nsc_pkg::CH_START);
        push_tag(sent_tag);
        push_byte($urandom_range(0, 9) == 0 ? field_char() : nsc_pkg::CH_COMMA);
        if (shape < 6)
            body_len = $urandom_range(nsc_pkg::BUFFER_DEPTH + 2, nsc_pkg::BUFFER_DEPTH + 50);
        else if (shape < 14)
            body_len = $urandom_range(40, 80);
        else
            body_len = $urandom_range(2, 60);
        for (int i = 0; i < body_len; i++) begin
            if (shape >= 6 && shape < 14 && $urandom_range(0, 9) < 7)
                push_byte(nsc_pkg::CH_COMMA);
            else
                push_byte(field_char());
        end
        if ($urandom_range(0, 99) < 40) begin
            push_byte(CH_STAR);
            push_byte(CH_DIGIT0 + nsc_pkg::BYTE_W'($urandom_range(0, 9)));
            push_byte(CH_UPPERA + nsc_pkg::BYTE_W'($urandom_range(0, 5)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            push_byte(nsc_pkg::CH_CR);
            push_byte(nsc_pkg::CH_LF);
        end else if (pick < 88) begin
            push_byte(nsc_pkg::CH_LF);
        end else if (pick < 94) begin
            push_byte(nsc_pkg::CH_CR);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) push_byte(field_char());
    endtask

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (rx_pending.size() != 0 || s_tvalid || owed_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic run_phase(logic [nsc_pkg::TAG_W-1:0] t, int count);
        int stop_at;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            if ($urandom_range(0, 99) < 80)
                push_sentence(t);
            else
                repeat ($urandom_range(1, 8))
                    push_byte(nsc_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        wait_drained();
    endtask

    task automatic write_tag(logic [nsc_pkg::TAG_W-1:0] t);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tag_setting = t;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge bytes, a matched sentence, lone LF, CR LF, then a second match cut short by a start
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(nsc_pkg::CH_START);
        push_tag(nsc_pkg::TAG_RESET);
        push_byte(nsc_pkg::CH_COMMA);
        push_byte(nsc_pkg::CH_COMMA);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(nsc_pkg::CH_LF);
        push_byte(nsc_pkg::CH_CR);
        push_byte(nsc_pkg::CH_LF);
        push_byte(CH_UPPERA);
        push_byte(nsc_pkg::CH_START);
        push_tag(nsc_pkg::TAG_RESET);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(nsc_pkg::CH_START);
        wait_drained();

        run_phase(nsc_pkg::TAG_RESET, 380);
        write_tag(TAG_ZERO);
        run_phase(TAG_ZERO, 150);
        write_tag(TAG_ONES);
        run_phase(TAG_ONES, 150);
        write_tag(TAG_RMC);
        run_phase(TAG_RMC, 250);
        write_tag(nsc_pkg::TAG_RESET);
        calm = 1'b1;
        run_phase(nsc_pkg::TAG_RESET, 300);
        calm = 1'b0;
        run_phase(nsc_pkg::TAG_RESET, 250);

        $display("Sent %0d bytes under five tag settings; %0d results checked",
                 bytes_sent, results_seen);
        $display("Buffer writes %0d, separators %0d, overflow flagged %0d, line complete %0d",
                 stores_seen, commas_seen, overflow_seen, complete_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
